[src/rob_pkg.sv]
// Shared types, constants and codes for the reorder buffer.
package rob_pkg;

  // Entry count must be a power of two so that the ring pointers wrap naturally.
  localparam int MAX_ENTRIES = 32;
  localparam int TAG_BITS    = 8;
  localparam int SEQ_BITS    = 48;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Stream and register port widths.
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;
  localparam int RES_W      = 35;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int SIZE_W     = 6;

  localparam logic REG_ROB_SIZE = 1'b0;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_COMMIT = 3'd1,
    OP_SQUASH = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_MARK   = 3'd4,
    OP_STATUS = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SQ_RD,
    S_SQ_CMP,
    S_SQ_FIN,
    S_LK_RD,
    S_LK_CMP,
    S_HD_RD,
    S_HD_CAP,
    S_OUT,
    S_SQ_ERD,
    S_SQ_EOUT
  } state_t;

  // One stored entry; the ready flags live in flip-flops in the top level.
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [SEQ_BITS-1:0] seq;
    logic                mem;
  } rob_entry_t;

  // One result word, listed from the top bit down.
  typedef struct packed {
    logic [7:0]  removed_tag;
    logic        removed_valid;
    logic        tag_found;
    logic [5:0]  occupancy;
    logic [5:0]  memory_count;
    logic [7:0]  head_tag;
    logic        head_is_ready;
    logic        full_flag;
    logic        empty_flag;
    logic [1:0]  status_code;
  } rob_result_t;

endpackage

[src/rob_store.sv]
// Entry memory of the reorder buffer: one write port, one registered read port.
module rob_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [rob_pkg::IDX_W-1:0] waddr,
  input  rob_pkg::rob_entry_t       wdata,
  input  logic [rob_pkg::IDX_W-1:0] raddr,
  output rob_pkg::rob_entry_t       rdata
);
  import rob_pkg::*;

  rob_entry_t mem_r [MAX_ENTRIES];
  rob_entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/reorder_buffer.sv]
// Reorder buffer top level: sequencer, ring pointers, ready flags and result register.
//
// An in-order reorder buffer held as a 32-entry ring. Commands arrive on the in_ stream
// (operation in in_tuser; tag, sequence number and memory flag in in_tdata) and each
// gives one or more result words on the out_ stream, the final one marked by out_tlast.
// The single register rob_size on the cfg_ APB port sets the entry count at which the
// buffer reports full; write it only while the block is idle.
//
// One command is handled at a time; in_tready is high only while the sequencer idles.
// The entry memory, with one write port and one registered read port, is walked:
//   push, status and commit: the command step, then a read of the head entry;
//   lookup and mark ready: a read and a compare per held entry, then the head read;
//   squash: a read and a compare per entry counted back from the tail, the head read,
//   then a read per removed entry, each giving one word, youngest first.
// The memory port and the one tag or sequence comparator make each walk go entry by entry.
// The next command is taken the cycle after the last word loads, even while that word
// still waits in the output register.
// When the receiver stalls, the word is held and the sequencer waits before loading the
// next one. Reset (rst_n low, synchronous) empties the buffer and sets rob_size to 32.
module reorder_buffer (
  input  logic                          clk,
  input  logic                          rst_n,
  // fields from bit 0: inst_tag[7:0], seq_number[55:8], is_memory_ref[56], zeros
  input  logic [rob_pkg::IN_DATA_W-1:0] in_tdata,
  // fields from bit 0: operation[2:0]
  input  logic [rob_pkg::IN_USER_W-1:0] in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // fields from bit 0: status_code[1:0], empty_flag[2], full_flag[3], head_is_ready[4],
  // head_tag[12:5], memory_count[18:13], occupancy[24:19], tag_found[25],
  // removed_valid[26], removed_tag[34:27], zeros
  output logic [rob_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rob_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [rob_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [rob_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import rob_pkg::*;

  // Control state.
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    memcnt_r, memcnt_nxt;
  logic [SIZE_W-1:0]   rob_size_r;
  logic [MAX_ENTRIES-1:0] ready_r, ready_nxt;
  logic                out_valid_r;

  // Per-command working registers.
  op_t                 op_r, op_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [SEQ_BITS-1:0] seq_r, seq_nxt;
  logic                mem_r, mem_nxt;
  status_t             status_r, status_nxt;
  logic                found_r, found_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [TAG_BITS-1:0] rtag_r, rtag_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic [CNT_W-1:0]    memrm_r, memrm_nxt;
  logic [TAG_BITS-1:0] head_tag_r, head_tag_nxt;
  rob_result_t         res_r;
  logic                last_r;

  // Memory port and result load controls.
  logic                we;
  rob_entry_t          wdata;
  logic [IDX_W-1:0]    raddr;
  rob_entry_t          rdata;
  logic                out_load;
  logic                out_rvalid;
  logic [TAG_BITS-1:0] out_rtag;
  logic                out_last;
  logic                out_free;
  logic [CNT_W-1:0]    eff_size;
  logic                full;
  logic                cfg_wr;
  rob_result_t         res_nxt;

  rob_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (tail_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Effective size: rob_size clamped to one up to the entry count.
  always_comb begin
    if (rob_size_r == '0) begin
      eff_size = CNT_W'(1);
    end else if (CNT_W'(rob_size_r) > CNT_W'(MAX_ENTRIES)) begin
      eff_size = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_size = CNT_W'(rob_size_r);
    end
  end

  assign full      = (count_r >= eff_size);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign wdata     = '{tag: tag_r, seq: seq_r, mem: mem_r};

  // Sequencer: next state, pointer updates and memory addressing.
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    memcnt_nxt   = memcnt_r;
    ready_nxt    = ready_r;
    op_nxt       = op_r;
    tag_nxt      = tag_r;
    seq_nxt      = seq_r;
    mem_nxt      = mem_r;
    status_nxt   = status_r;
    found_nxt    = found_r;
    rvalid_nxt   = rvalid_r;
    rtag_nxt     = rtag_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    memrm_nxt    = memrm_r;
    head_tag_nxt = head_tag_r;
    we           = 1'b0;
    raddr        = head_r;
    out_load     = 1'b0;
    out_rvalid   = 1'b0;
    out_rtag     = '0;
    out_last     = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = op_t'(in_tuser);
          tag_nxt    = in_tdata[TAG_BITS-1:0];
          seq_nxt    = in_tdata[TAG_BITS +: SEQ_BITS];
          mem_nxt    = in_tdata[TAG_BITS + SEQ_BITS];
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          rvalid_nxt = 1'b0;
          rtag_nxt   = '0;
          k_nxt      = '0;
          j_nxt      = '0;
          memrm_nxt  = '0;
          state_nxt  = S_EXEC;
        end
      end

      // The head entry was read during the idle cycle and is in rdata now.
      S_EXEC: begin
        state_nxt = S_HD_RD;
        case (op_r)
          OP_PUSH: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              we                = 1'b1;
              ready_nxt[tail_r] = 1'b0;
              tail_nxt          = tail_r + IDX_W'(1);
              count_nxt         = count_r + CNT_W'(1);
              memcnt_nxt        = memcnt_r + CNT_W'(mem_r);
            end
          end
          OP_COMMIT: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (!ready_r[head_r]) begin
              status_nxt = ST_NOT_READY;
            end else begin
              rvalid_nxt = 1'b1;
              rtag_nxt   = rdata.tag;
              memcnt_nxt = memcnt_r - CNT_W'(rdata.mem);
              head_nxt   = head_r + IDX_W'(1);
              count_nxt  = count_r - CNT_W'(1);
            end
          end
          OP_SQUASH: state_nxt = S_SQ_RD;
          OP_LOOKUP, OP_MARK: state_nxt = S_LK_RD;
          default: state_nxt = S_HD_RD;
        endcase
      end

      // Squash, first pass: count younger entries from the tail without changing state.
      S_SQ_RD: begin
        raddr = tail_r - IDX_W'(1) - k_r[IDX_W-1:0];
        if (k_r == count_r) begin
          state_nxt = S_SQ_FIN;
        end else begin
          state_nxt = S_SQ_CMP;
        end
      end

      S_SQ_CMP: begin
        raddr = tail_r - IDX_W'(1) - k_r[IDX_W-1:0];
        if (rdata.seq <= seq_r) begin
          state_nxt = S_SQ_FIN;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          memrm_nxt = memrm_r + CNT_W'(rdata.mem);
          state_nxt = S_SQ_RD;
        end
      end

      // Drop the counted entries at once; their memory contents stay for the second pass.
      S_SQ_FIN: begin
        tail_nxt   = tail_r - k_r[IDX_W-1:0];
        count_nxt  = count_r - k_r;
        memcnt_nxt = memcnt_r - memrm_r;
        state_nxt  = S_HD_RD;
      end

      // Lookup and mark ready walk every held entry from the head.
      S_LK_RD: begin
        raddr = head_r + k_r[IDX_W-1:0];
        if (k_r == count_r) begin
          state_nxt = S_HD_RD;
        end else begin
          state_nxt = S_LK_CMP;
        end
      end

      S_LK_CMP: begin
        raddr = head_r + k_r[IDX_W-1:0];
        if (rdata.tag == tag_r) begin
          found_nxt = 1'b1;
          if (op_r == OP_MARK) begin
            ready_nxt[head_r + k_r[IDX_W-1:0]] = 1'b1;
          end
        end
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_LK_RD;
      end

      S_HD_RD: begin
        state_nxt = S_HD_CAP;
      end

      S_HD_CAP: begin
        head_tag_nxt = (count_r == '0) ? '0 : rdata.tag;
        if (op_r == OP_SQUASH && k_r != '0) begin
          state_nxt = S_SQ_ERD;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_rvalid = rvalid_r;
          out_rtag   = rtag_r;
          state_nxt  = S_IDLE;
        end
      end

      // Squash, second pass: one word per removed entry, youngest first.
      S_SQ_ERD: begin
        raddr     = tail_r + k_r[IDX_W-1:0] - IDX_W'(1) - j_r[IDX_W-1:0];
        state_nxt = S_SQ_EOUT;
      end

      S_SQ_EOUT: begin
        raddr    = tail_r + k_r[IDX_W-1:0] - IDX_W'(1) - j_r[IDX_W-1:0];
        out_last = (j_r == k_r - CNT_W'(1));
        if (out_free) begin
          out_load   = 1'b1;
          out_rvalid = 1'b1;
          out_rtag   = rdata.tag;
          j_nxt      = j_r + CNT_W'(1);
          state_nxt  = out_last ? S_IDLE : S_SQ_ERD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Result word built from the live state after the command.
  always_comb begin
    res_nxt.status_code   = status_r;
    res_nxt.empty_flag    = (count_r == '0);
    res_nxt.full_flag     = full;
    res_nxt.head_is_ready = (count_r != '0) && ready_r[head_r];
    res_nxt.head_tag      = head_tag_r;
    res_nxt.memory_count  = memcnt_r;
    res_nxt.occupancy     = count_r;
    res_nxt.tag_found     = found_r;
    res_nxt.removed_valid = out_rvalid;
    res_nxt.removed_tag   = out_rtag;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      memcnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      memcnt_r <= memcnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and ready flags; only held entries are ever read.
  always_ff @(posedge clk) begin
    ready_r    <= ready_nxt;
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    seq_r      <= seq_nxt;
    mem_r      <= mem_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    rvalid_r   <= rvalid_nxt;
    rtag_r     <= rtag_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    memrm_r    <= memrm_nxt;
    head_tag_r <= head_tag_nxt;
    if (out_load) begin
      res_r  <= res_nxt;
      last_r <= out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - RES_W)'(0), res_r};
  assign out_tlast  = last_r;

  // Configuration register.
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rob_size_r <= SIZE_W'(MAX_ENTRIES);
    end else if (cfg_wr && cfg_paddr[2] == REG_ROB_SIZE) begin
      rob_size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ROB_SIZE) ?
                      {(CFG_DW - SIZE_W)'(0), rob_size_r} : '0;

endmodule

[src/rob_checker.sv]
// Port-level checker for the reorder buffer, bound to the top level.
module rob_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic [rob_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready
);
  import rob_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // The empty flag agrees with the occupancy.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] == (out_tdata[24:19] == 6'd0)))
    else $error("empty flag disagrees with occupancy");

  // An empty buffer shows no head and no memory references.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[12:4] == 9'd0 && out_tdata[18:13] == 6'd0)
    else $error("empty buffer reports head or memory entries");

  // A removed entry is only reported with an ok status.
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> out_tdata[1:0] == ST_OK)
    else $error("removed entry reported with an error status");

endmodule

bind reorder_buffer rob_checker u_rob_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[dv/tb_top.sv]
// Self-checking testbench for the reorder buffer: directed table, random streams, size changes.
`timescale 1ns / 1ps

module tb_top;
  import rob_pkg::*;

  // Operation codes that the block does not define; they must behave as a status request.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [CFG_AW-1:0] ROB_SIZE_ADDR = CFG_AW'({REG_ROB_SIZE, 2'b00});
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_OFF_CYCLES = 400;

  // One expected result word and its end-of-command marker.
  typedef struct {
    rob_result_t word;
    logic        last;
  } rob_word_t;

  // One row of the directed table; typed rows carry their result written out by hand.
  typedef struct {
    logic [2:0]          op;
    logic [7:0]          tag;
    logic [SEQ_BITS-1:0] seq;
    logic                mem;
    logic                typed;
    rob_result_t         want;
  } cmd_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  reorder_buffer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the buffer, updated whenever a command word is accepted.
  logic [7:0]          shadow_tag [MAX_ENTRIES];
  logic [SEQ_BITS-1:0] shadow_seq [MAX_ENTRIES];
  logic                shadow_mem [MAX_ENTRIES];
  logic                shadow_rdy [MAX_ENTRIES];
  logic [IDX_W-1:0]    shadow_head = '0;
  logic [IDX_W-1:0]    shadow_tail = '0;
  int                  shadow_count = 0;
  logic [SIZE_W-1:0]   shadow_size = 6'd32;

  rob_word_t           awaited_words[$];
  cmd_row_t            directed[$];
  int                  mismatch_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_request = 0;
  logic                hold_taken = 1'b0;
  int                  hold_left = 0;
  int                  cycle_count = 0;
  logic [SEQ_BITS-1:0] next_seq;

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Appends one expected word at the end of the queue.
  task automatic queue_word(input rob_result_t w, input logic last);
    rob_word_t item;
    item.word = w;
    item.last = last;
    awaited_words = {awaited_words, item};
  endtask

  // Appends one row to the directed table.
  task automatic add_row(input cmd_row_t r);
    directed = {directed, r};
  endtask

  function automatic int effective_size();
    if (shadow_size == 0) return 1;
    if (shadow_size > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(shadow_size);
  endfunction

  // Builds a result word from the shadow state as it stands after the command.
  function automatic rob_result_t shadow_word(input status_t st, input logic found,
                                              input logic rvalid, input logic [7:0] rtag);
    rob_result_t w;
    int mem_n;
    mem_n = 0;
    for (int i = 0; i < shadow_count; i++)
      mem_n += shadow_mem[IDX_W'(shadow_head + i)];
    w = '0;
    w.status_code   = st;
    w.empty_flag    = (shadow_count == 0);
    w.full_flag     = (shadow_count >= effective_size());
    w.head_is_ready = (shadow_count != 0) && shadow_rdy[shadow_head];
    w.head_tag      = (shadow_count != 0) ? shadow_tag[shadow_head] : 8'h00;
    w.memory_count  = 6'(mem_n);
    w.occupancy     = 6'(shadow_count);
    w.tag_found     = found;
    w.removed_valid = rvalid;
    w.removed_tag   = rvalid ? rtag : 8'h00;
    return w;
  endfunction

  // Applies one command to the shadow buffer and queues the words it must produce.
  task automatic shadow_step(input logic [2:0] op, input logic [7:0] tag,
                             input logic [SEQ_BITS-1:0] seq, input logic mem);
    logic [7:0]       gone[$];
    logic [7:0]       retired;
    logic [IDX_W-1:0] slot;
    logic             found;
    found = 1'b0;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= effective_size()) begin
          queue_word(shadow_word(ST_FULL, 1'b0, 1'b0, 8'h00), 1'b1);
        end else begin
          shadow_tag[shadow_tail] = tag;
          shadow_seq[shadow_tail] = seq;
          shadow_mem[shadow_tail] = mem;
          shadow_rdy[shadow_tail] = 1'b0;
          shadow_tail++;
          shadow_count++;
          queue_word(shadow_word(ST_OK, 1'b0, 1'b0, 8'h00), 1'b1);
        end
      end
      OP_COMMIT: begin
        if (shadow_count == 0) begin
          queue_word(shadow_word(ST_EMPTY, 1'b0, 1'b0, 8'h00), 1'b1);
        end else if (!shadow_rdy[shadow_head]) begin
          queue_word(shadow_word(ST_NOT_READY, 1'b0, 1'b0, 8'h00), 1'b1);
        end else begin
          retired = shadow_tag[shadow_head];
          shadow_head++;
          shadow_count--;
          queue_word(shadow_word(ST_OK, 1'b0, 1'b1, retired), 1'b1);
        end
      end
      OP_SQUASH: begin
        // Walk back from the tail while entries are younger than the boundary.
        while (shadow_count > 0 && shadow_seq[IDX_W'(shadow_tail - 1)] > seq) begin
          shadow_tail--;
          gone = {gone, shadow_tag[shadow_tail]};
          shadow_count--;
        end
        if (gone.size() == 0)
          queue_word(shadow_word(ST_OK, 1'b0, 1'b0, 8'h00), 1'b1);
        foreach (gone[i])
          queue_word(shadow_word(ST_OK, 1'b0, 1'b1, gone[i]), (i == gone.size() - 1));
      end
      OP_LOOKUP, OP_MARK: begin
        // Mark ready sets every held entry that carries the tag.
        for (int i = 0; i < shadow_count; i++) begin
          slot = IDX_W'(shadow_head + i);
          if (shadow_tag[slot] == tag) begin
            found = 1'b1;
            if (op == OP_MARK) shadow_rdy[slot] = 1'b1;
          end
        end
        queue_word(shadow_word(ST_OK, found, 1'b0, 8'h00), 1'b1);
      end
      default: begin
        queue_word(shadow_word(ST_OK, 1'b0, 1'b0, 8'h00), 1'b1);
      end
    endcase
  endtask

  // Offers one command word, idling first at random, and updates the shadow on acceptance.
  task automatic send_command(input logic [2:0] op, input logic [7:0] tag,
                              input logic [SEQ_BITS-1:0] seq, input logic mem);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {7'b0, mem, seq, tag};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    shadow_step(op, tag, seq, mem);
  endtask

  // Draws one command, mostly well-formed program order with random content.
  task automatic send_random(input int push_pct);
    logic [2:0]          op;
    logic [7:0]          tag;
    logic [SEQ_BITS-1:0] seq;
    logic [IDX_W-1:0]    pick;
    int                  roll;
    roll = $urandom_range(0, 99);
    tag  = 8'($urandom);
    seq  = SEQ_BITS'({$urandom, $urandom});
    pick = shadow_head;
    if (shadow_count > 0)
      pick = IDX_W'(shadow_head + $urandom_range(0, shadow_count - 1));
    if (roll < push_pct) begin
      op = OP_PUSH;
      if ($urandom_range(0, 9) != 0) begin
        seq = next_seq;
        next_seq = next_seq + SEQ_BITS'($urandom_range(1, 3));
      end
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        op = OP_COMMIT;
      end else if (roll < 60) begin
        op = OP_MARK;
        // Favour the head so that commits retire often.
        if (shadow_count > 0 && $urandom_range(0, 5) != 0)
          tag = $urandom_range(0, 1) ? shadow_tag[shadow_head] : shadow_tag[pick];
      end else if (roll < 75) begin
        op = OP_SQUASH;
        if (shadow_count > 0 && $urandom_range(0, 4) != 0) begin
          seq = shadow_seq[pick];
          next_seq = seq + 1'b1;
        end
      end else if (roll < 90) begin
        op = OP_LOOKUP;
        if (shadow_count > 0 && $urandom_range(0, 2) != 0) tag = shadow_tag[pick];
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_STATUS;
          1:       op = OP_SPARE6;
          default: op = OP_SPARE7;
        endcase
      end
    end
    send_command(op, tag, seq, 1'($urandom));
  endtask

  // Lowers the command stream and waits until every expected word has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  // APB access: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic write, input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= ROB_SIZE_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_rob_size();
    logic [CFG_DW-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata !== CFG_DW'(shadow_size)) report_mismatch("rob_size readback", rdata, shadow_size);
  endtask

  // Writes the size with random upper bits, which the register ignores, then reads it back.
  task automatic write_rob_size(input logic [SIZE_W-1:0] size);
    logic [CFG_DW-1:0] wdata;
    logic [CFG_DW-1:0] rdata;
    wdata = $urandom;
    wdata[SIZE_W-1:0] = size;
    apb_access(1'b1, wdata, rdata);
    shadow_size = size;
    check_rob_size();
  endtask

  function automatic cmd_row_t row(input logic [2:0] op, input logic [7:0] tag,
                                   input logic [SEQ_BITS-1:0] seq, input logic mem);
    return '{op, tag, seq, mem, 1'b0, '0};
  endfunction

  // A row whose single result is written out; nothing found or removed in these.
  function automatic cmd_row_t typed_row(input logic [2:0] op, input logic [7:0] tag,
                                         input logic [SEQ_BITS-1:0] seq, input logic mem,
                                         input status_t st, input logic empty,
                                         input logic hd_rdy, input logic [7:0] hd_tag,
                                         input int mem_n, input int occ);
    rob_result_t w;
    w = '0;
    w.status_code   = st;
    w.empty_flag    = empty;
    w.head_is_ready = hd_rdy;
    w.head_tag      = hd_tag;
    w.memory_count  = 6'(mem_n);
    w.occupancy     = 6'(occ);
    return '{op, tag, seq, mem, 1'b1, w};
  endfunction

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != 0 && !hold_taken) begin
      hold_left = hold_request;
      hold_taken = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    rob_result_t got;
    rob_word_t   want;
    if (rst_n && out_tvalid && out_tready) begin
      got = rob_result_t'(out_tdata[RES_W-1:0]);
      if (awaited_words.size() == 0) begin
        report_mismatch("word with nothing expected", got, 0);
      end else begin
        want = awaited_words[0];
        awaited_words.delete(0);
        if (got.status_code !== want.word.status_code)
          report_mismatch("status_code", got.status_code, want.word.status_code);
        if (got.empty_flag !== want.word.empty_flag)
          report_mismatch("empty_flag", got.empty_flag, want.word.empty_flag);
        if (got.full_flag !== want.word.full_flag)
          report_mismatch("full_flag", got.full_flag, want.word.full_flag);
        if (got.head_is_ready !== want.word.head_is_ready)
          report_mismatch("head_is_ready", got.head_is_ready, want.word.head_is_ready);
        if (got.head_tag !== want.word.head_tag)
          report_mismatch("head_tag", got.head_tag, want.word.head_tag);
        if (got.memory_count !== want.word.memory_count)
          report_mismatch("memory_count", got.memory_count, want.word.memory_count);
        if (got.occupancy !== want.word.occupancy)
          report_mismatch("occupancy", got.occupancy, want.word.occupancy);
        if (got.tag_found !== want.word.tag_found)
          report_mismatch("tag_found", got.tag_found, want.word.tag_found);
        if (got.removed_valid !== want.word.removed_valid)
          report_mismatch("removed_valid", got.removed_valid, want.word.removed_valid);
        if (got.removed_tag !== want.word.removed_tag)
          report_mismatch("removed_tag", got.removed_tag, want.word.removed_tag);
        if (out_tlast !== want.last)
          report_mismatch("out_tlast", out_tlast, want.last);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then random phases at several sizes.
  initial begin
    localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;
    int       phase_size[7];
    int       phase_items[7];
    int       phase_push[7];
    int       phase_mode[7];

    phase_size  = '{-1, 4, 1, 0, 63, 17, 32};
    phase_items = '{80, 50, 45, 45, 70, 50, 40};
    phase_push  = '{70, 40, 40, 35, 55, 45, 40};
    phase_mode  = '{0, 0, 1, 1, 2, 2, 2};

    next_seq = SEQ_BITS'({$urandom, $urandom}) >> 4;

    // Empty buffer, every operation but push, including the two spare codes.
    add_row(typed_row(OP_COMMIT, 8'h00, '0, 1'b0, ST_EMPTY, 1'b1, 1'b0, 8'h00, 0, 0));
    add_row(typed_row(OP_SQUASH, 8'h00, SEQ_MAX, 1'b0, ST_OK, 1'b1, 1'b0, 8'h00, 0, 0));
    add_row(typed_row(OP_LOOKUP, 8'hFF, '0, 1'b0, ST_OK, 1'b1, 1'b0, 8'h00, 0, 0));
    add_row(typed_row(OP_MARK, 8'h00, '0, 1'b0, ST_OK, 1'b1, 1'b0, 8'h00, 0, 0));
    add_row(typed_row(OP_STATUS, 8'hFF, SEQ_MAX, 1'b1, ST_OK, 1'b1, 1'b0, 8'h00, 0, 0));
    add_row(typed_row(OP_SPARE6, 8'h5A, '0, 1'b1, ST_OK, 1'b1, 1'b0, 8'h00, 0, 0));
    add_row(typed_row(OP_SPARE7, 8'hA5, SEQ_MAX, 1'b0, ST_OK, 1'b1, 1'b0, 8'h00, 0, 0));
    // Field extremes, then a head that is not ready yet.
    add_row(typed_row(OP_PUSH, 8'hFF, SEQ_MAX, 1'b1, ST_OK, 1'b0, 1'b0, 8'hFF, 1, 1));
    add_row(row(OP_PUSH, 8'h00, '0, 1'b0));
    add_row(typed_row(OP_COMMIT, 8'h00, '0, 1'b0,
                      ST_NOT_READY, 1'b0, 1'b0, 8'hFF, 1, 2));
    add_row(row(OP_MARK, 8'hFF, '0, 1'b0));
    add_row(row(OP_LOOKUP, 8'h00, '0, 1'b0));
    add_row(row(OP_LOOKUP, 8'h55, '0, 1'b0));
    // Duplicate tag: one mark sets both entries.
    add_row(row(OP_PUSH, 8'h00, 48'd5, 1'b1));
    add_row(row(OP_MARK, 8'h00, '0, 1'b0));
    add_row(row(OP_PUSH, 8'hA5, 48'd10, 1'b1));
    // Squash of two entries, then one that removes nothing, then one at boundary zero.
    add_row(row(OP_SQUASH, 8'h00, 48'd4, 1'b0));
    add_row(row(OP_SQUASH, 8'h00, SEQ_MAX, 1'b0));
    add_row(row(OP_PUSH, 8'h3C, SEQ_MAX, 1'b0));
    add_row(row(OP_SQUASH, 8'h00, '0, 1'b0));
    // Retire the two ready entries, then commit on an empty buffer again.
    add_row(row(OP_COMMIT, 8'h00, '0, 1'b0));
    add_row(row(OP_COMMIT, 8'h00, '0, 1'b0));
    add_row(typed_row(OP_COMMIT, 8'h00, '0, 1'b0, ST_EMPTY, 1'b1, 1'b0, 8'h00, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_rob_size();

    send_idle_pct = 36;
    recv_idle_pct = 54;
    foreach (directed[i]) begin
      send_command(directed[i].op, directed[i].tag, directed[i].seq, directed[i].mem);
      if (directed[i].typed)
        awaited_words[awaited_words.size() - 1].word = directed[i].want;
    end

    for (int p = 0; p < 7; p++) begin
      drain();
      case (phase_mode[p])
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase_size[p] >= 0) write_rob_size(SIZE_W'(phase_size[p]));
      // Back-pressure test: the receiver stops while commands keep coming.
      if (p == 4) hold_request = HOLD_OFF_CYCLES;
      for (int n = 0; n < phase_items[p]; n++)
        send_random(phase_push[p]);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_words.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
